FILE: rtl/dqp_pkg.sv
// Shared types and constants of the DNS query parser.
// Used by dqp_front, dqp_queue, dqp_back and dns_query_parser; no dependencies.
package dqp_pkg;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [8:0] LIMIT_RESET = 9'd256;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // header byte positions that close a 16-bit word
  localparam logic [3:0] POS_ID_LO = 4'd1;
  localparam logic [3:0] POS_FLAGS_LO = 4'd3;
  localparam logic [3:0] POS_QDCOUNT_LO = 4'd5;
  localparam logic [3:0] POS_ANCOUNT_LO = 4'd7;
  localparam logic [3:0] POS_NSCOUNT_LO = 4'd9;
  localparam logic [3:0] POS_HDR_END = 4'd12;

  // positions within qtype/qclass
  localparam logic [2:0] TAIL_TYPE_LO = 3'd1;
  localparam logic [2:0] TAIL_CLASS_LO = 3'd3;
  localparam logic [2:0] TAIL_END = 3'd4;

  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [15:0] CLASS_ANY = 16'd255;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_SECTIONS = 3'd2;
  localparam logic [2:0] ST_QDCOUNT = 3'd3;
  localparam logic [2:0] ST_NAME_LONG = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_CLASS = 3'd6;

  localparam logic KIND_NAME = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one classified input byte: up to two results
  typedef struct packed {
    logic        has_name;
    logic [7:0]  name_byte;
    logic        has_sum;
    logic [2:0]  status;
    logic [15:0] query_id;
    logic        is_response;
    logic [3:0]  opcode;
    logic        recursion_desired;
    logic [8:0]  name_length;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } entry_t;

endpackage

FILE: rtl/dqp_front.sv
// Front end of the DNS query parser: header capture, name tracking, tail
// capture and status. Emits one classified entry per byte that has results.
// Depends on dqp_pkg.
module dqp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [8:0]        name_limit,
  output logic              push,
  output dqp_pkg::entry_t   entry
);

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] msg_id_r, msg_id_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        sect_err_r, sect_err_nxt;
  logic        cnt_err_r, cnt_err_nxt;
  logic [8:0]  name_cnt_r, name_cnt_nxt;
  logic        name_fin_r, name_fin_nxt;
  logic [2:0]  tail_r, tail_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] class_r, class_nxt;
  logic [15:0] word;
  logic [2:0]  status;

  assign word = {held_r, data_byte};

  always_comb begin
    pos_nxt = pos_r;
    msg_id_nxt = msg_id_r;
    flag_nxt = flag_r;
    held_nxt = held_r;
    sect_err_nxt = sect_err_r;
    cnt_err_nxt = cnt_err_r;
    name_cnt_nxt = name_cnt_r;
    name_fin_nxt = name_fin_r;
    tail_nxt = tail_r;
    type_nxt = type_r;
    class_nxt = class_r;
    entry = '0;

    if (pos_r < dqp_pkg::POS_HDR_END) begin
      if (!pos_r[0]) begin
        held_nxt = data_byte;
      end else begin
        case (pos_r)
          dqp_pkg::POS_ID_LO:      msg_id_nxt = word;
          dqp_pkg::POS_FLAGS_LO:   flag_nxt = word;
          dqp_pkg::POS_QDCOUNT_LO: cnt_err_nxt = (word != 16'd1);
          dqp_pkg::POS_ANCOUNT_LO,
          dqp_pkg::POS_NSCOUNT_LO: if (word != 16'd0) sect_err_nxt = 1'b1;
          default: ;
        endcase
      end
      pos_nxt = pos_r + 4'd1;
    end else if (!name_fin_r) begin
      entry.has_name = 1'b1;
      entry.name_byte = data_byte;
      if (name_cnt_r != dqp_pkg::COUNT_MAX) name_cnt_nxt = name_cnt_r + 9'd1;
      if (data_byte == 8'd0) name_fin_nxt = 1'b1;
    end else if (tail_r < dqp_pkg::TAIL_END) begin
      case (tail_r)
        dqp_pkg::TAIL_TYPE_LO:  type_nxt = word;
        dqp_pkg::TAIL_CLASS_LO: class_nxt = word;
        default:                held_nxt = data_byte;
      endcase
      tail_nxt = tail_r + 3'd1;
    end

    // status sees the state after this word
    if (pos_nxt < dqp_pkg::POS_HDR_END)               status = dqp_pkg::ST_SHORT;
    else if (sect_err_nxt)                            status = dqp_pkg::ST_SECTIONS;
    else if (cnt_err_nxt)                             status = dqp_pkg::ST_QDCOUNT;
    else if (name_cnt_nxt > name_limit)               status = dqp_pkg::ST_NAME_LONG;
    else if (!name_fin_nxt || tail_nxt < dqp_pkg::TAIL_END)
                                                      status = dqp_pkg::ST_TRUNCATED;
    else if (class_nxt != dqp_pkg::CLASS_IN && class_nxt != dqp_pkg::CLASS_ANY)
                                                      status = dqp_pkg::ST_CLASS;
    else                                              status = dqp_pkg::ST_OK;

    entry.has_sum = last_byte;
    entry.status = status;
    entry.query_id = msg_id_nxt;
    entry.is_response = flag_nxt[15];
    entry.opcode = flag_nxt[14:11];
    entry.recursion_desired = flag_nxt[8];
    entry.name_length = name_cnt_nxt;
    entry.query_type = type_nxt;
    entry.query_class = class_nxt;
  end

  assign push = accept && (entry.has_name || entry.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r <= '0;
      msg_id_r <= '0;
      flag_r <= '0;
      held_r <= '0;
      sect_err_r <= 1'b0;
      cnt_err_r <= 1'b0;
      name_cnt_r <= '0;
      name_fin_r <= 1'b0;
      tail_r <= '0;
      type_r <= '0;
      class_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      msg_id_r <= msg_id_nxt;
      flag_r <= flag_nxt;
      held_r <= held_nxt;
      sect_err_r <= sect_err_nxt;
      cnt_err_r <= cnt_err_nxt;
      name_cnt_r <= name_cnt_nxt;
      name_fin_r <= name_fin_nxt;
      tail_r <= tail_nxt;
      type_r <= type_nxt;
      class_r <= class_nxt;
    end
  end

endmodule

FILE: rtl/dqp_queue.sv
// Short register queue of classified entries between front and back.
// Depends on dqp_pkg.
module dqp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dqp_pkg::entry_t   push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output dqp_pkg::entry_t   head
);

  dqp_pkg::entry_t                 slot_r [dqp_pkg::QUEUE_DEPTH];
  logic [dqp_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [dqp_pkg::QPTR_W:0]        count_r, count_nxt;

  assign full = (count_r == (dqp_pkg::QPTR_W+1)'(dqp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

FILE: rtl/dqp_back.sv
// Back end of the DNS query parser: expands queue entries into name-byte and
// summary results and holds them in the output register. Depends on dqp_pkg.
module dqp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  dqp_pkg::entry_t   head,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_kind,
  output logic [7:0]        out_name_byte,
  output logic [2:0]        out_status,
  output logic [15:0]       out_query_id,
  output logic              out_is_response,
  output logic [3:0]        out_opcode,
  output logic              out_recursion_desired,
  output logic [8:0]        out_name_length,
  output logic [15:0]       out_query_type,
  output logic [15:0]       out_query_class,
  output logic              out_last_result
);

  logic        valid_r;
  logic        name_done_r;
  logic        load;
  logic        send_name;
  logic        kind_r;
  logic [7:0]  name_byte_r;
  logic [2:0]  status_r;
  logic [15:0] query_id_r;
  logic        is_resp_r;
  logic [3:0]  opcode_r;
  logic        rd_r;
  logic [8:0]  name_len_r;
  logic [15:0] qtype_r;
  logic [15:0] qclass_r;

  assign load = q_valid && (!valid_r || out_ready);
  assign send_name = head.has_name && !name_done_r;
  // hold the entry while its summary is still to come
  assign pop = load && !(send_name && head.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      name_done_r <= 1'b0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (load) name_done_r <= send_name && head.has_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_name) begin
        kind_r <= dqp_pkg::KIND_NAME;
        name_byte_r <= head.name_byte;
        status_r <= '0;
        query_id_r <= '0;
        is_resp_r <= 1'b0;
        opcode_r <= '0;
        rd_r <= 1'b0;
        name_len_r <= '0;
        qtype_r <= '0;
        qclass_r <= '0;
      end else begin
        kind_r <= dqp_pkg::KIND_SUMMARY;
        name_byte_r <= '0;
        status_r <= head.status;
        query_id_r <= head.query_id;
        is_resp_r <= head.is_response;
        opcode_r <= head.opcode;
        rd_r <= head.recursion_desired;
        name_len_r <= head.name_length;
        qtype_r <= head.query_type;
        qclass_r <= head.query_class;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_kind = kind_r;
  assign out_name_byte = name_byte_r;
  assign out_status = status_r;
  assign out_query_id = query_id_r;
  assign out_is_response = is_resp_r;
  assign out_opcode = opcode_r;
  assign out_recursion_desired = rd_r;
  assign out_name_length = name_len_r;
  assign out_query_type = qtype_r;
  assign out_query_class = qclass_r;
  assign out_last_result = kind_r;

endmodule

FILE: rtl/dns_query_parser.sv
// DNS query parser top level: front end, entry queue, back end, limit register.
// Depends on dqp_pkg, dqp_front, dqp_queue and dqp_back.
//
// Takes one datagram byte per cycle, every cycle, while the four-entry queue
// between front and back has room. Each byte is classified in the cycle it is
// accepted; a question name byte yields one result, the final byte yields a
// summary, and a final byte that is also a name byte yields both, in that
// order. The back end issues one result per cycle from the output register
// while out_ready is high; with an idle queue the first result of a byte goes
// through a queue slot and then the output register. Configuration writes
// are always taken (cfg_ready is high) and set name_limit, which resets to 256.
module dns_query_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_name_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_name_byte,
  output logic [2:0]  out_status,
  output logic [15:0] out_query_id,
  output logic        out_is_response,
  output logic [3:0]  out_opcode,
  output logic        out_recursion_desired,
  output logic [8:0]  out_name_length,
  output logic [15:0] out_query_type,
  output logic [15:0] out_query_class,
  output logic        out_last_result
);

  logic [8:0]       name_limit_r;
  logic             accept;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  dqp_pkg::entry_t  push_entry;
  dqp_pkg::entry_t  head;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= dqp_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      name_limit_r <= cfg_name_limit;
    end
  end

  dqp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .name_limit (name_limit_r),
    .push       (push),
    .entry      (push_entry)
  );

  dqp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  dqp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .head                  (head),
    .pop                   (pop),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_kind              (out_kind),
    .out_name_byte         (out_name_byte),
    .out_status            (out_status),
    .out_query_id          (out_query_id),
    .out_is_response       (out_is_response),
    .out_opcode            (out_opcode),
    .out_recursion_desired (out_recursion_desired),
    .out_name_length       (out_name_length),
    .out_query_type        (out_query_type),
    .out_query_class       (out_query_class),
    .out_last_result       (out_last_result)
  );

  // a name word carries nothing but its byte
  a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == dqp_pkg::KIND_NAME |->
      out_status == dqp_pkg::ST_OK && out_query_id == 16'd0 && out_name_length == 9'd0)
    else $error("name result carries summary fields");

  // a short datagram never reached the name or tail
  a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == dqp_pkg::KIND_SUMMARY && out_status == dqp_pkg::ST_SHORT |->
      out_name_length == 9'd0 && out_query_type == 16'd0 && out_query_class == 16'd0)
    else $error("short datagram reports name or tail data");

  // queue never accepts a push when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("queue overflow");

  // an entry with both results stays until its summary is loaded
  a_hold_split: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && pop && head.has_name && head.has_sum |=> out_kind == dqp_pkg::KIND_SUMMARY)
    else $error("split entry popped before its summary");

endmodule
